>>> rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP address cache: request and result
// payloads, controller commands and status, and the controller state codes.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;

    // Request modes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Broadcast pair held in slot 0 after reset
    localparam logic [IP_W-1:0]  BCAST_IP  = {IP_W{1'b1}};
    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    typedef struct packed {
        logic             mode;
        logic [IP_W-1:0]  ip_address;
        logic [MAC_W-1:0] mac_address;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac_found;
    } rsp_t;

    typedef struct packed {
        logic insert;    // write the request pair at the write pointer
        logic load;      // capture lookup key, rewind the scan index
        logic scan;      // scan in progress
        logic emit_hit;  // publish matching MAC
        logic emit_miss; // publish a miss
    } cmd_t;

    typedef struct packed {
        logic match;     // compared slot equals the key
        logic exhausted; // all used slots compared, none matched
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

>>> rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Controller: accepts requests, runs the lookup scan and decides when to
// publish a hit or a miss.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    mode,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_INSERT)
                    begin
                        cmd.insert = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                // first match wins: compares arrive in slot order
                priority if (status.match)
                begin
                    cmd.emit_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.exhausted)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> rtl/arpc_datapath.sv
// ----------------------------------------------------------------------------
// arpc_datapath
// Address and MAC stores, write pointer, used count, scan index, comparator
// and result register.
// ----------------------------------------------------------------------------
module arpc_datapath
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    request,
    input  cmd_t    cmd,
    output status_t status,
    output logic    done,
    output rsp_t    result
);

    localparam int unsigned PTR_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    logic [IP_W-1:0]  addr_mem [ENTRIES];
    logic [MAC_W-1:0] mac_mem  [ENTRIES];

    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic             slot0_written_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             cmp_valid_reg;
    logic             cmp_zero_reg;
    logic [IP_W-1:0]  key_reg;
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             issue;
    logic [IP_W-1:0]  cmp_ip;
    logic [MAC_W-1:0] cmp_mac;
    logic             bcast_slot;

    // Slot 0 reads as the broadcast pair until the pointer first wraps onto it
    assign bcast_slot = cmp_zero_reg && !slot0_written_reg;
    assign cmp_ip     = bcast_slot ? BCAST_IP  : rd_ip_reg;
    assign cmp_mac    = bcast_slot ? BCAST_MAC : rd_mac_reg;

    assign status.match     = cmp_valid_reg && (cmp_ip == key_reg);
    assign status.exhausted = (idx_reg >= used_reg) && !cmp_valid_reg;

    // Stop fetching once a hit has been seen
    assign issue = cmd.scan && !status.match && (idx_reg < used_reg);

    assign wp_next   = (wp_reg == PTR_W'(ENTRIES - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign used_next = (used_reg == CNT_W'(ENTRIES)) ? used_reg : used_reg + CNT_W'(1);

    always_comb
    begin
        rsp_next = rsp_reg;
        priority if (cmd.emit_hit)
        begin
            rsp_next.hit       = 1'b1;
            rsp_next.mac_found = cmp_mac;
        end
        else if (cmd.emit_miss)
        begin
            rsp_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg            <= PTR_W'(1);
            used_reg          <= CNT_W'(1);
            slot0_written_reg <= 1'b0;
            idx_reg           <= '0;
            cmp_valid_reg     <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                wp_reg   <= wp_next;
                used_reg <= used_next;
                if (wp_reg == '0)
                begin
                    slot0_written_reg <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            cmp_valid_reg <= issue;
            done_reg      <= cmd.emit_hit || cmd.emit_miss;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= request.ip_address;
        end
        if (issue)
        begin
            cmp_zero_reg <= (idx_reg == '0);
        end
        rsp_reg <= rsp_next;
    end

    // Stores: one write port at the pointer, one registered read at the index
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            addr_mem[wp_reg] <= request.ip_address;
            mac_mem[wp_reg]  <= request.mac_address;
        end
        if (issue)
        begin
            rd_ip_reg  <= addr_mem[idx_reg[PTR_W-1:0]];
            rd_mac_reg <= mac_mem[idx_reg[PTR_W-1:0]];
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

>>> rtl/arp_address_cache.sv
// ----------------------------------------------------------------------------
// arp_address_cache
// Lookup: the scan compares one slot per cycle, in slot order, through the single
//   read port of the stores until the first match or until all used slots are
//   compared; busy falls as done rises, so the next request can be taken while done is high.
// Insert: no result; inserts can follow each other every cycle while the block is idle.
// Reset: slot 0 holds the broadcast pair, count 1, pointer 1; no clearing
//   pass. The receiver cannot stall; each result is flagged by done for one cycle.
// ----------------------------------------------------------------------------
module arp_address_cache
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    // Command and status between controller and datapath
    cmd_t    cmd;
    status_t status;

    // Controller: accept requests, sequence the lookup scan
    arpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (request.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: stores, pointer, count, comparator, result register
    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

    // Hit and miss are never published together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_hit && cmd.emit_miss))
    else $error("hit and miss emitted together");

    // A miss always carries a zero MAC
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.mac_found == '0))
    else $error("miss with nonzero MAC");

    // Results never come in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("back-to-back results");

    // An insert never makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.mode == MODE_INSERT) |=> !busy)
    else $error("insert left block busy");

    // Busy rises only after an accepted lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && request.mode == MODE_LOOKUP))
    else $error("busy without lookup request");

endmodule
